// ===== design/sfd_pkg.sv =====
package sfd_pkg;

   // Width and reset value of the delay length register
   localparam int unsigned DELAY_BITS  = 17;
   localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(48000);

   // Ring clearing after reset, then normal running
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } ctrl_state_type;

endpackage

// ===== design/stereo_feedback_delay_unit.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_left_in, req_right_in
// rsp       out        rsp_valid/rsp_stall  rsp_left_out, rsp_right_out
// csr       in         csr_valid/csr_ready  csr_delay_samples
//
// One stereo request per cycle while req_stall is low; the ring is read at acceptance,
// then come the sums and the ring write-back, then the output register that holds the result.
// After reset both rings are cleared one entry a cycle, across all RING_DEPTH entries,
// with req_stall held high; csr writes are taken throughout.
// A stall on rsp holds the output register, and req_stall rises only once the
// in-flight request can no longer move forward.
module stereo_feedback_delay_unit #(
   parameter int unsigned RING_DEPTH  = 131072,
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [SAMPLE_BITS-1:0]           req_left_in,
   input  logic [SAMPLE_BITS-1:0]           req_right_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [SAMPLE_BITS-1:0]           rsp_left_out,
   output logic [SAMPLE_BITS-1:0]           rsp_right_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sfd_pkg::DELAY_BITS-1:0]   csr_delay_samples
);

   import sfd_pkg::*;

   localparam int unsigned AW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int unsigned CW   = (AW + 1 > DELAY_BITS) ? AW + 1 : DELAY_BITS;
   localparam int unsigned HALF = RING_DEPTH / 2;
   localparam logic [CW-1:0] HALF_C = CW'(HALF);
   localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

   ctrl_state_type state_ff, state_in;
   logic [AW-1:0]  clr_idx_ff, clr_idx_in;
   logic           clearing;

   logic [DELAY_BITS-1:0] delay_ff;
   logic [AW-1:0]         ptr_ff, ptr_in;

   logic                   p1_valid_ff;
   logic [AW-1:0]          p1_wr_ff;
   logic [SAMPLE_BITS-1:0] p1_left_x_ff, p1_right_x_ff;
   logic                   p1_fwd_ff;
   logic [SAMPLE_BITS-1:0] p1_left_fwd_ff, p1_right_fwd_ff;

   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_left_ff, rsp_right_ff;

   logic accept, out_free, p1_adv;

   logic [CW-1:0] delay_ext, d_eff, ring_size, wr_ext, rd_ext, nxt_ext;
   logic [AW-1:0] wr_addr, rd_addr;

   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [SAMPLE_BITS-1:0] mem_left_wdata, mem_right_wdata;
   logic [SAMPLE_BITS-1:0] left_q, right_q, left_d, right_d;
   logic [SAMPLE_BITS-1:0] left_s, right_s, left_y, right_y;

   // Handshakes
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign p1_adv    = p1_valid_ff && out_free;
   assign req_stall = !(state_ff == ST_RUN && (!p1_valid_ff || out_free));
   assign accept    = req_valid && !req_stall;
   assign clearing  = (state_ff == ST_CLEAR);

   // Clearing sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_IDX) begin
               state_in   = ST_RUN;
               clr_idx_in = '0;
            end
         end
         ST_RUN: begin
            clr_idx_in = '0;
         end
         default: begin
            state_in   = ST_CLEAR;
            clr_idx_in = '0;
         end
      endcase
   end

   // Delay length register
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         delay_ff <= csr_delay_samples;
      end
   end

   // Effective delay, ring size and read/write indices
   always_comb begin
      delay_ext = CW'(delay_ff);
      if (delay_ext == '0) begin
         d_eff = CW'(1);
      end else if (delay_ext > HALF_C) begin
         d_eff = HALF_C;
      end else begin
         d_eff = delay_ext;
      end
      ring_size = d_eff << 1;
      wr_ext = CW'(ptr_ff);
      if (wr_ext >= ring_size) begin
         wr_ext = '0;
      end
      rd_ext  = (wr_ext >= d_eff) ? (wr_ext - d_eff) : (wr_ext + d_eff);
      nxt_ext = wr_ext + CW'(1);
      if (nxt_ext >= ring_size) begin
         nxt_ext = '0;
      end
      wr_addr = wr_ext[AW-1:0];
      rd_addr = rd_ext[AW-1:0];
      ptr_in  = nxt_ext[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (accept) begin
         ptr_ff <= ptr_in;
      end
   end

   // Ring write port: clearing pass or write-back of the stored sum
   assign mem_wr_en       = clearing || p1_adv;
   assign mem_wr_addr     = clearing ? clr_idx_ff : p1_wr_ff;
   assign mem_left_wdata  = clearing ? '0 : left_s;
   assign mem_right_wdata = clearing ? '0 : right_s;

   sfd_ring #(
      .DEPTH (RING_DEPTH),
      .AW    (AW),
      .WIDTH (SAMPLE_BITS)
   ) u_left_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_left_wdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (left_q)
   );

   sfd_ring #(
      .DEPTH (RING_DEPTH),
      .AW    (AW),
      .WIDTH (SAMPLE_BITS)
   ) u_right_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_right_wdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (right_q)
   );

   // Stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= accept || (p1_valid_ff && !out_free);
      end
   end

   // Stage 1 payload; a write-back landing on the address read in the same
   // cycle is forwarded, since the ring returns the old contents
   always_ff @(posedge clock) begin
      if (accept) begin
         p1_wr_ff        <= wr_addr;
         p1_left_x_ff    <= req_left_in;
         p1_right_x_ff   <= req_right_in;
         p1_fwd_ff       <= p1_adv && (p1_wr_ff == rd_addr);
         p1_left_fwd_ff  <= left_s;
         p1_right_fwd_ff <= right_s;
      end
   end

   assign left_d  = p1_fwd_ff ? p1_left_fwd_ff  : left_q;
   assign right_d = p1_fwd_ff ? p1_right_fwd_ff : right_q;

   sfd_echo_calc #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_left_calc (
      .x (p1_left_x_ff),
      .d (left_d),
      .s (left_s),
      .y (left_y)
   );

   sfd_echo_calc #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_right_calc (
      .x (p1_right_x_ff),
      .d (right_d),
      .s (right_s),
      .y (right_y)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p1_adv || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (p1_adv) begin
         rsp_left_ff  <= left_y;
         rsp_right_ff <= right_y;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule

// ===== design/sfd_ring.sv =====
module sfd_ring #(
   parameter int unsigned DEPTH = 131072,
   parameter int unsigned AW    = 17,
   parameter int unsigned WIDTH = 24
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] ring_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; a read at the address being
   // written returns the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sfd_echo_calc.sv =====
module sfd_echo_calc #(
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic [SAMPLE_BITS-1:0] x,
   input  logic [SAMPLE_BITS-1:0] d,
   output logic [SAMPLE_BITS-1:0] s,
   output logic [SAMPLE_BITS-1:0] y
);

   localparam int unsigned SB = SAMPLE_BITS;
   localparam logic [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

   logic [SB:0] sum_store;
   logic [SB:0] sum_out;

   // Stored value: x plus half of d (floor), saturated
   always_comb begin
      sum_store = {x[SB-1], x} + {d[SB-1], d[SB-1], d[SB-1:1]};
      if (sum_store[SB] != sum_store[SB-1]) begin
         s = sum_store[SB] ? SAT_MIN : SAT_MAX;
      end else begin
         s = sum_store[SB-1:0];
      end
   end

   // Output: stored value plus d, saturated
   always_comb begin
      sum_out = {s[SB-1], s} + {d[SB-1], d};
      if (sum_out[SB] != sum_out[SB-1]) begin
         y = sum_out[SB] ? SAT_MIN : SAT_MAX;
      end else begin
         y = sum_out[SB-1:0];
      end
   end

endmodule
